/* hdl/dmcwt_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmcwt_pkg
// Shared constants, controller states and the command/status bundles that
// join the cache controller to its datapath.
// ----------------------------------------------------------------------------
package dmcwt_pkg;

  localparam int ADDRESS_BITS_DEF = 10;
  localparam int LINE_BITS_DEF    = 4;
  localparam int OFFSET_BITS_DEF  = 2;

  localparam int DATA_W = 32;
  localparam int CNT_W  = 32;

  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP,
    ST_FILL,
    ST_RESP
  } state_e;

  // Controller to datapath
  typedef struct packed {
    logic clear;
    logic load;
    logic lookup;
    logic fill;
    logic respond;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic clear_last;
    logic is_write;
    logic present;
    logic fill_done;
    logic out_free;
  } status_t;

endpackage

/* hdl/direct_mapped_cache_write_through.sv */
`timescale 1ns / 1ps
// Sequence: a write or a read hit goes from the input transfer through lookup to the
//   result register; a read miss first fills the line from the backing memory.
// Only one access is in flight: in_stall_o stays high until the result of the last
//   access has been taken into the result register.
// Reset: the backing memory is cleared one word per cycle, all 2^ADDRESS_BITS (1024) words,
//   with in_stall_o high; valid bits and counters clear at once.
// ----------------------------------------------------------------------------
// direct_mapped_cache_write_through
// Direct-mapped, write-through, no-write-allocate cache in front of a
// word-addressed backing memory, with hit, miss and eviction counters.
// ----------------------------------------------------------------------------
module direct_mapped_cache_write_through
  import dmcwt_pkg::*;
#(
  parameter int ADDRESS_BITS = ADDRESS_BITS_DEF,
  parameter int LINE_BITS    = LINE_BITS_DEF,
  parameter int OFFSET_BITS  = OFFSET_BITS_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic                    in_op_i,
  input  logic [ADDRESS_BITS-1:0] in_address_i,
  input  logic [DATA_W-1:0]       in_write_data_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic [DATA_W-1:0]       out_read_data_o,
  output logic                    out_hit_o,
  output logic                    out_evicted_o,
  output logic [CNT_W-1:0]        out_hit_count_o,
  output logic [CNT_W-1:0]        out_miss_count_o,
  output logic [CNT_W-1:0]        out_eviction_count_o
);

  cmd_t    cmd;
  status_t status;

  dmcwt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  dmcwt_dp #(
    .ADDRESS_BITS (ADDRESS_BITS),
    .LINE_BITS    (LINE_BITS),
    .OFFSET_BITS  (OFFSET_BITS)
  ) u_dp (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cmd_i                (cmd),
    .status_o             (status),
    .in_op_i              (in_op_i),
    .in_address_i         (in_address_i),
    .in_write_data_i      (in_write_data_i),
    .out_valid_o          (out_valid_o),
    .out_stall_i          (out_stall_i),
    .out_read_data_o      (out_read_data_o),
    .out_hit_o            (out_hit_o),
    .out_evicted_o        (out_evicted_o),
    .out_hit_count_o      (out_hit_count_o),
    .out_miss_count_o     (out_miss_count_o),
    .out_eviction_count_o (out_eviction_count_o)
  );

  // Every result bumps exactly one of hit and miss totals
  a_one_count_per_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.respond |=> (out_hit_count_o + out_miss_count_o) ==
      ($past(out_hit_count_o) + $past(out_miss_count_o) + CNT_W'(1)))
    else $error("hit/miss totals did not advance by one");

  // Only one access in flight
  a_single_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("second transfer taken while an access is in progress");

  // A hit never reports an eviction
  a_hit_no_evict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_hit_o && out_evicted_o))
    else $error("hit flagged together with eviction");

  // Eviction counter holds while a result is stalled
  a_counts_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> $stable(out_eviction_count_o))
    else $error("eviction total moved under a stalled result");

endmodule

/* hdl/dmcwt_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmcwt_ram
// Generic simple dual-port RAM: one write port, one read port with a
// registered read that holds its data while the read enable is low.
// ----------------------------------------------------------------------------
module dmcwt_ram #(
  parameter int WIDTH  = 32,
  parameter int ADDR_W = 6
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  localparam int DEPTH = 1 << ADDR_W;

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* hdl/dmcwt_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmcwt_ctrl
// Cache controller: memory clearing after reset, request intake, tag lookup,
// line fill sequencing and result hand-off.
// ----------------------------------------------------------------------------
module dmcwt_ctrl
  import dmcwt_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_stall_o,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (status_i.clear_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_LOOKUP;
      end
      ST_LOOKUP: begin
        if (status_i.is_write || status_i.present) state_d = ST_RESP;
        else state_d = ST_FILL;
      end
      ST_FILL: begin
        if (status_i.fill_done) state_d = ST_RESP;
      end
      ST_RESP: begin
        if (status_i.out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      ST_CLEAR:  cmd_o.clear = 1'b1;
      ST_IDLE: begin
        in_stall_o = 1'b0;
        cmd_o.load = in_valid_i;
      end
      ST_LOOKUP: cmd_o.lookup = 1'b1;
      ST_FILL:   cmd_o.fill = 1'b1;
      ST_RESP:   cmd_o.respond = status_i.out_free;
      default: begin
        cmd_o      = '0;
        in_stall_o = 1'b1;
      end
    endcase
  end

endmodule

/* hdl/dmcwt_dp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmcwt_dp
// Cache datapath: request registers, tag/valid arrays, line and backing
// memories, fill counter, hit/miss/eviction counters and result register.
// ----------------------------------------------------------------------------
module dmcwt_dp
  import dmcwt_pkg::*;
#(
  parameter int ADDRESS_BITS = ADDRESS_BITS_DEF,
  parameter int LINE_BITS    = LINE_BITS_DEF,
  parameter int OFFSET_BITS  = OFFSET_BITS_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  cmd_t                    cmd_i,
  output status_t                 status_o,
  input  logic                    in_op_i,
  input  logic [ADDRESS_BITS-1:0] in_address_i,
  input  logic [DATA_W-1:0]       in_write_data_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic [DATA_W-1:0]       out_read_data_o,
  output logic                    out_hit_o,
  output logic                    out_evicted_o,
  output logic [CNT_W-1:0]        out_hit_count_o,
  output logic [CNT_W-1:0]        out_miss_count_o,
  output logic [CNT_W-1:0]        out_eviction_count_o
);

  localparam int NUM_LINES = 1 << LINE_BITS;
  localparam int CACHE_AW  = LINE_BITS + OFFSET_BITS;
  localparam int EXT_W     = ADDRESS_BITS + LINE_BITS + OFFSET_BITS;
  localparam int TAG_BITS  = (ADDRESS_BITS > LINE_BITS + OFFSET_BITS) ?
                             ADDRESS_BITS - LINE_BITS - OFFSET_BITS : 0;
  localparam int TAG_W     = (TAG_BITS > 0) ? TAG_BITS : 1;
  localparam logic [OFFSET_BITS:0] FILL_ONE = (OFFSET_BITS + 1)'(1);
  localparam logic [ADDRESS_BITS-1:0] CLR_ONE = ADDRESS_BITS'(1);

  // Request registers
  logic                    req_op_q;
  logic [ADDRESS_BITS-1:0] req_addr_q;
  logic [DATA_W-1:0]       req_wdata_q;

  logic [EXT_W-1:0]        addr_ext;
  logic [OFFSET_BITS-1:0]  req_offs;
  logic [LINE_BITS-1:0]    req_line;
  logic [TAG_W-1:0]        req_tag;

  // Tag store
  logic [NUM_LINES-1:0]    valid_q;
  logic [TAG_W-1:0]        tag_q [NUM_LINES];
  logic                    present;
  logic                    is_read;

  // Lookup results
  logic                    present_q;
  logic                    evict_q;

  // Fill sequencing
  logic [OFFSET_BITS:0]    fill_cnt_q;
  logic                    fill_pend_q;
  logic [OFFSET_BITS-1:0]  fill_idx_q;
  logic                    fill_issue;
  logic [DATA_W-1:0]       word_q;

  // Clearing pass
  logic [ADDRESS_BITS-1:0] clr_addr_q;

  // Memory ports
  logic                    mem_we, mem_re;
  logic [ADDRESS_BITS-1:0] mem_waddr, mem_raddr;
  logic [DATA_W-1:0]       mem_wdata, mem_rdata;
  logic                    cache_we, cache_re;
  logic [CACHE_AW-1:0]     cache_waddr, cache_raddr;
  logic [DATA_W-1:0]       cache_wdata, cache_rdata;

  // Result
  logic                    out_valid_q;
  logic [DATA_W-1:0]       out_rdata_q;
  logic                    out_hit_q;
  logic                    out_evict_q;
  logic [CNT_W-1:0]        hits_q, misses_q, evicts_q;
  logic [DATA_W-1:0]       result_data;
  logic                    out_free;

  assign addr_ext = {{(LINE_BITS + OFFSET_BITS){1'b0}}, req_addr_q};
  assign req_offs = req_addr_q[OFFSET_BITS-1:0];
  assign req_line = addr_ext[OFFSET_BITS +: LINE_BITS];

  generate
    if (TAG_BITS > 0) begin : g_tag
      assign req_tag = req_addr_q[ADDRESS_BITS-1 -: TAG_W];
    end else begin : g_no_tag
      assign req_tag = '0;
    end
  endgenerate

  assign is_read = (req_op_q == OP_READ);
  assign present = valid_q[req_line] && (tag_q[req_line] == req_tag);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_op_q    <= in_op_i;
      req_addr_q  <= in_address_i;
      req_wdata_q <= in_write_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (cmd_i.lookup && is_read && !present) begin
      valid_q[req_line] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.lookup && is_read && !present) begin
      tag_q[req_line] <= req_tag;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.lookup) begin
      present_q <= present;
      evict_q   <= is_read && !present && valid_q[req_line];
    end
  end

  // Fill: issue one backing read per cycle, write each word back in the cycle after its read
  assign fill_issue = cmd_i.fill && !fill_cnt_q[OFFSET_BITS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_cnt_q  <= '0;
      fill_pend_q <= 1'b0;
    end else if (cmd_i.lookup) begin
      fill_cnt_q  <= '0;
      fill_pend_q <= 1'b0;
    end else if (cmd_i.fill) begin
      fill_pend_q <= fill_issue;
      if (fill_issue) fill_cnt_q <= fill_cnt_q + FILL_ONE;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fill_issue) begin
      fill_idx_q <= fill_cnt_q[OFFSET_BITS-1:0];
    end
    if (cmd_i.fill && fill_pend_q && (fill_idx_q == req_offs)) begin
      word_q <= mem_rdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_addr_q <= '0;
    end else if (cmd_i.clear) begin
      clr_addr_q <= clr_addr_q + CLR_ONE;
    end
  end

  // Backing memory: clearing pass, write-through / write-around, line fill
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = req_addr_q;
    mem_wdata = req_wdata_q;
    if (cmd_i.clear) begin
      mem_we    = 1'b1;
      mem_waddr = clr_addr_q;
      mem_wdata = '0;
    end else if (cmd_i.lookup && !is_read) begin
      mem_we = 1'b1;
    end
  end

  assign mem_re    = fill_issue;
  assign mem_raddr = {req_addr_q[ADDRESS_BITS-1:OFFSET_BITS],
                      fill_cnt_q[OFFSET_BITS-1:0]};

  // Line store: write hit update, fill write-back, read hit lookup
  always_comb begin
    cache_we    = 1'b0;
    cache_waddr = {req_line, req_offs};
    cache_wdata = req_wdata_q;
    if (cmd_i.lookup && !is_read && present) begin
      cache_we = 1'b1;
    end else if (cmd_i.fill && fill_pend_q) begin
      cache_we    = 1'b1;
      cache_waddr = {req_line, fill_idx_q};
      cache_wdata = mem_rdata;
    end
  end

  assign cache_re    = cmd_i.lookup && is_read && present;
  assign cache_raddr = {req_line, req_offs};

  dmcwt_ram #(
    .WIDTH  (DATA_W),
    .ADDR_W (ADDRESS_BITS)
  ) u_backing_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  dmcwt_ram #(
    .WIDTH  (DATA_W),
    .ADDR_W (CACHE_AW)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (cache_we),
    .waddr_i (cache_waddr),
    .wdata_i (cache_wdata),
    .re_i    (cache_re),
    .raddr_i (cache_raddr),
    .rdata_o (cache_rdata)
  );

  // Result register and running counters; counters only move on a hand-off
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    if (!is_read) result_data = '0;
    else if (present_q) result_data = cache_rdata;
    else result_data = word_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      hits_q      <= '0;
      misses_q    <= '0;
      evicts_q    <= '0;
    end else begin
      if (cmd_i.respond) begin
        out_valid_q <= 1'b1;
        hits_q      <= hits_q + CNT_W'(present_q);
        misses_q    <= misses_q + CNT_W'(!present_q);
        evicts_q    <= evicts_q + CNT_W'(evict_q);
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.respond) begin
      out_rdata_q <= result_data;
      out_hit_q   <= present_q;
      out_evict_q <= evict_q;
    end
  end

  assign status_o.clear_last = &clr_addr_q;
  assign status_o.is_write   = !is_read;
  assign status_o.present    = present;
  assign status_o.fill_done  = fill_cnt_q[OFFSET_BITS];
  assign status_o.out_free   = out_free;

  assign out_valid_o          = out_valid_q;
  assign out_read_data_o      = out_rdata_q;
  assign out_hit_o            = out_hit_q;
  assign out_evicted_o        = out_evict_q;
  assign out_hit_count_o      = hits_q;
  assign out_miss_count_o     = misses_q;
  assign out_eviction_count_o = evicts_q;

endmodule
